>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the probe classifier modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

>>> rtl/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Types, constants and helpers of the LED probe color tree classifier.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int unsigned LpcSamples    = 16;
  localparam int unsigned LpcStepCount  = 5;
  localparam int unsigned LpcEntryRegs  = 5;
  localparam int unsigned LpcQueueDepth = 2;
  localparam int unsigned LpcCfgW       = 52;
  localparam int unsigned LpcLevelW     = 10;

  localparam logic [2:0] LpcNextReady = 3'd7;
  localparam logic [2:0] LpcColorNone = 3'd0;
  localparam logic [2:0] LpcColorBad  = 3'd7;

  // register indexes; step entries occupy 0 .. LpcEntryRegs-1
  localparam logic [2:0] RegGuardBand  = 3'd5;
  localparam logic [2:0] RegUpperValid = 3'd6;

  localparam logic [LpcCfgW-1:0] EntryRst0 = 52'd2147483716928;
  localparam logic [LpcCfgW-1:0] EntryRst1 = 52'd3775036556;
  localparam logic [LpcCfgW-1:0] EntryRst2 = 52'd2111063291542698;
  localparam logic [LpcCfgW-1:0] EntryRst3 = 52'd882186282901060;
  localparam logic [LpcCfgW-1:0] EntryRst4 = 52'd222909644659932;
  localparam logic [9:0]         GuardRst  = 10'd4;
  localparam logic [9:0]         UpperRst  = 10'd850;

  typedef enum logic [1:0] {
    CmdStart   = 2'd0,
    CmdSample  = 2'd1,
    CmdTimeout = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [9:0] blue;
    logic [9:0] green;
    logic [9:0] red;
    logic [2:0] lt_color;
    logic [2:0] next_lt;
    logic [2:0] gt_color;
    logic [2:0] next_gt;
    logic [9:0] limit;
  } step_entry_t;

  typedef struct packed {
    step_entry_t [LpcEntryRegs-1:0] entry;
    logic [9:0]                     guard_band;
    logic [9:0]                     upper_valid;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] light_sample;
  } in_t;

  typedef struct packed {
    logic [9:0] led_red;
    logic [9:0] led_green;
    logic [9:0] led_blue;
    logic       done_res;
    logic [2:0] color_code;
  } out_t;

  // queued job: final color, or LED levels of step "code"
  typedef struct packed {
    logic       final_res;
    logic [2:0] code;
  } job_t;

  // steps without a register read as all zero
  function automatic step_entry_t entry_at(cfg_t cfg, logic [2:0] idx);
    step_entry_t e;
    e = '0;
    if (idx < 3'(LpcEntryRegs)) begin
      e = cfg.entry[idx];
    end
    return e;
  endfunction

endpackage

>>> rtl/led_probe_color_tree_classifier.sv
// ----------------------------------------------------------------------------
// led_probe_color_tree_classifier
// LED probe color classifier walking a threshold decision tree.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------
//  in       | input     | in_valid_i / in_stall_o  | in_data_i  (in_t)
//  out      | output    | out_valid_o / out_stall_i| out_data_o (out_t)
//  cfg      | input     | cfg_we_i, no wait        | cfg_addr_i, cfg_wdata_i
//
//  One input transfer per cycle while in_stall_o is low. The transfer that
//  completes a block of SAMPLES samples is followed by a decision cycle
//  (reciprocal multiply of the sum, limit and guard compares) with
//  in_stall_o high. A start or timeout result passes the job queue and
//  the output register before it shows on out_valid_o; a block result
//  first passes the decision register (dec_q) as well.
//  Reset (rst_ni low, async) clears the probe state and the job queue and
//  reloads the default tree, guard band and upper limit.
//  Output stall first fills the two-entry job queue, then raises in_stall_o.
// ----------------------------------------------------------------------------
module led_probe_color_tree_classifier #(
  parameter int unsigned SAMPLES = lpc_pkg::LpcSamples
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lpc_pkg::in_t                in_data_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lpc_pkg::out_t               out_data_o,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_addr_i,
  input  logic [lpc_pkg::LpcCfgW-1:0] cfg_wdata_i
);
  import lpc_pkg::*;

  cfg_t cfg;
  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  job_t q_job;
  logic pop;

  // register bank, shared by decision and LED level lookup
  lpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // front: commands, accumulation, tree decision
  lpc_front #(
    .SAMPLES (SAMPLES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .cfg_i      (cfg),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // decouples the decision from output stalls
  lpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  // back: LED level lookup and output register
  lpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_job_i     (q_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/lpc_cfg.sv
// ----------------------------------------------------------------------------
// lpc_cfg
// Configuration register bank: five step entries, guard band, upper limit.
// ----------------------------------------------------------------------------
module lpc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_addr_i,
  input  logic [lpc_pkg::LpcCfgW-1:0]   cfg_wdata_i,
  output lpc_pkg::cfg_t                 cfg_o
);
  import lpc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entry[0]    <= step_entry_t'(EntryRst0);
      cfg_q.entry[1]    <= step_entry_t'(EntryRst1);
      cfg_q.entry[2]    <= step_entry_t'(EntryRst2);
      cfg_q.entry[3]    <= step_entry_t'(EntryRst3);
      cfg_q.entry[4]    <= step_entry_t'(EntryRst4);
      cfg_q.guard_band  <= GuardRst;
      cfg_q.upper_valid <= UpperRst;
    end else if (cfg_we_i) begin
      if (cfg_addr_i < 3'(LpcEntryRegs)) begin
        cfg_q.entry[cfg_addr_i] <= step_entry_t'(cfg_wdata_i);
      end else if (cfg_addr_i == RegGuardBand) begin
        cfg_q.guard_band <= cfg_wdata_i[9:0];
      end else if (cfg_addr_i == RegUpperValid) begin
        cfg_q.upper_valid <= cfg_wdata_i[9:0];
      end
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/lpc_front.sv
// ----------------------------------------------------------------------------
// lpc_front
// Command decode, sample accumulation and tree decision; emits jobs.
// ----------------------------------------------------------------------------
module lpc_front #(
  parameter int unsigned SAMPLES = lpc_pkg::LpcSamples
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  lpc_pkg::in_t   in_data_i,
  output logic           in_stall_o,
  input  lpc_pkg::cfg_t  cfg_i,
  input  logic           q_full_i,
  output logic           push_o,
  output lpc_pkg::job_t  job_o
);
  import lpc_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned SumW     = 12 + $clog2(SAMPLES);
  localparam int unsigned CntW     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned Div      = SAMPLES * 4;
  localparam int unsigned DivShift = SumW + $clog2(Div);
  localparam int unsigned Recip    = ((1 << DivShift) + Div - 1) / Div;
  localparam int unsigned RecipW   = SumW + 1;
  localparam int unsigned ProdW    = SumW + RecipW;

  logic            busy_q, busy_d;
  logic [2:0]      step_q, step_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            dec_q, dec_d;
  logic [SumW-1:0] dec_sum_q, dec_sum_d;

  logic            accept;
  logic [SumW-1:0] sum_add;
  logic [ProdW-1:0] prod;
  logic [9:0]      avg;
  logic [9:0]      diff;
  logic            above;
  logic            fail;
  logic [2:0]      nxt;
  logic [2:0]      color;
  step_entry_t     ent;

  // decision cycle blocks input; a full queue too
  assign in_stall_o = dec_q || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign sum_add    = sum_q + SumW'(in_data_i.light_sample);

  // average by reciprocal multiply, exact over the whole sum range
  assign prod  = ProdW'(dec_sum_q) * ProdW'(RecipW'(Recip));
  assign avg   = prod[DivShift +: 10];
  assign ent   = entry_at(cfg_i, step_q);
  assign above = avg > ent.limit;
  assign diff  = above ? (avg - ent.limit) : (ent.limit - avg);
  assign fail  = (avg > cfg_i.upper_valid) || (avg == ent.limit) ||
                 (diff < cfg_i.guard_band);
  assign nxt   = above ? ent.next_gt : ent.next_lt;
  assign color = above ? ent.gt_color : ent.lt_color;

  always_comb begin
    busy_d    = busy_q;
    step_d    = step_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    dec_d     = 1'b0;
    dec_sum_d = dec_sum_q;
    push_o    = 1'b0;
    job_o     = '0;
    if (dec_q) begin
      push_o = 1'b1;
      if (fail || (nxt != LpcNextReady && nxt >= 3'(LpcStepCount))) begin
        job_o  = '{final_res: 1'b1, code: LpcColorNone};
        busy_d = 1'b0;
      end else if (nxt == LpcNextReady) begin
        job_o  = '{final_res: 1'b1,
                   code: (color == LpcColorBad) ? LpcColorNone : color};
        busy_d = 1'b0;
      end else begin
        job_o  = '{final_res: 1'b0, code: nxt};
        step_d = nxt;
      end
    end else if (accept) begin
      case (cmd_e'(in_data_i.command))
        CmdStart: begin
          busy_d = 1'b1;
          step_d = 3'd0;
          sum_d  = '0;
          cnt_d  = '0;
          push_o = 1'b1;
          job_o  = '{final_res: 1'b0, code: 3'd0};
        end
        CmdTimeout: begin
          if (busy_q) begin
            busy_d = 1'b0;
            sum_d  = '0;
            cnt_d  = '0;
            push_o = 1'b1;
            job_o  = '{final_res: 1'b1, code: LpcColorNone};
          end
        end
        CmdSample: begin
          if (busy_q) begin
            if (cnt_q == CntW'(SAMPLES - 1)) begin
              dec_d     = 1'b1;
              dec_sum_d = sum_add;
              sum_d     = '0;
              cnt_d     = '0;
            end else begin
              sum_d = sum_add;
              cnt_d = cnt_q + CntW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 3'd0;
      sum_q  <= '0;
      cnt_q  <= '0;
      dec_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      dec_q  <= dec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_sum_q <= dec_sum_d;
  end

  `ASSERT_NEVER(a_push_when_full, push_o && q_full_i, "job pushed into full queue")
  `ASSERT_CLK(a_dec_one_cycle, dec_q |=> !dec_q, "decision pending two cycles")
  `ASSERT_CLK(a_dec_pushes, dec_q |-> push_o, "decision without a job")
  `ASSERT_CLK(a_dec_busy, dec_q |-> busy_q, "decision while idle")

endmodule

>>> rtl/lpc_queue.sv
// ----------------------------------------------------------------------------
// lpc_queue
// Small job queue between the decision front and the output back.
// ----------------------------------------------------------------------------
module lpc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lpc_pkg::job_t  job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lpc_pkg::job_t  job_o
);
  import lpc_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned PtrW = (LpcQueueDepth > 1) ? $clog2(LpcQueueDepth) : 1;
  localparam int unsigned CntW = $clog2(LpcQueueDepth + 1);

  job_t            mem_q [LpcQueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    n = (p == PtrW'(LpcQueueDepth - 1)) ? '0 : p + PtrW'(1);
    return n;
  endfunction

  assign full_o  = cnt_q == CntW'(LpcQueueDepth);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `ASSERT_NEVER(a_pop_empty, pop_i && !valid_o, "pop from empty queue")
  `ASSERT_NEVER(a_cnt_range, cnt_q > CntW'(LpcQueueDepth), "queue count overflow")
  `ASSERT_CLK(a_cnt_up, push_i && !pop_i |=> cnt_q == $past(cnt_q) + CntW'(1),
              "queue count missed a push")

endmodule

>>> rtl/lpc_back.sv
// ----------------------------------------------------------------------------
// lpc_back
// Turns queued jobs into result transfers held in an output register.
// ----------------------------------------------------------------------------
module lpc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lpc_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  lpc_pkg::job_t  q_job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lpc_pkg::out_t  out_data_o
);
  import lpc_pkg::*;
  `include "assert_macros.svh"

  logic        out_valid_q;
  out_t        out_q, out_d;
  step_entry_t ent;

  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);
  assign ent   = entry_at(cfg_i, q_job_i.code);

  always_comb begin
    out_d = '0;
    if (q_job_i.final_res) begin
      out_d.done_res   = 1'b1;
      out_d.color_code = q_job_i.code;
    end else begin
      out_d.led_red   = ent.red;
      out_d.led_green = ent.green;
      out_d.led_blue  = ent.blue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_CLK(a_done_led_off,
              out_valid_q && out_q.done_res |-> out_q.led_red == '0 &&
              out_q.led_green == '0 && out_q.led_blue == '0,
              "final result with LED on")
  `ASSERT_CLK(a_levels_no_color, out_valid_q && !out_q.done_res |-> out_q.color_code == '0,
              "level result carries a color")
  `ASSERT_NEVER(a_final_bad_color, pop_o && q_job_i.final_res && q_job_i.code == LpcColorBad,
                "color code 7 reached the output")

endmodule
